@@ rtl/core/isv_pkg.sv @@
// identifier segment validator: shared types, limits, status codes and character tests
// no dependencies; used by the interfaces' users, the step logic and the top level
`timescale 1ns / 1ps

package isv_pkg;

    // limits of the identifier and of one segment
    localparam int unsigned MAX_LENGTH  = 255;
    localparam int unsigned MAX_SEGMENT = 64;

    // counters hold one past the limit so that they saturate there
    localparam int unsigned TOT_W = $clog2(MAX_LENGTH + 2);
    localparam int unsigned SEG_W = $clog2(MAX_SEGMENT + 2);

    // number of leading segment bytes kept for the reserved name check
    localparam int unsigned HEAD_BYTES = 4;

    // status codes
    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_EMPTY     = 4'd1,
        ST_TOO_LONG  = 4'd2,
        ST_CONTROL   = 4'd3,
        ST_BAD_DOT   = 4'd4,
        ST_RESERVED  = 4'd5,
        ST_BAD_START = 4'd6,
        ST_BAD_CHAR  = 4'd7,
        ST_SEG_LONG  = 4'd8,
        ST_TRAIL_DOT = 4'd9
    } t_status;

    // special characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;

    // reserved device names, first character in the low byte
    localparam logic [23:0] RES_CON = 24'h6e6f63;
    localparam logic [23:0] RES_PRN = 24'h6e7270;
    localparam logic [23:0] RES_AUX = 24'h787561;
    localparam logic [23:0] RES_NUL = 24'h6c756e;
    localparam logic [23:0] RES_COM = 24'h6d6f63;
    localparam logic [23:0] RES_LPT = 24'h74706c;

    // one request on the input channel
    typedef struct packed {
        logic [7:0] char_byte;
        logic       dotted;
        logic       last_item;
        logic       empty_marker;
    } t_item;

    // running state over one identifier
    typedef struct packed {
        logic                    at_start;
        logic [SEG_W-1:0]        seg_len;
        logic [TOT_W-1:0]        tot_len;
        logic [8*HEAD_BYTES-1:0] head;
        t_status                 first_err;
    } t_scan;

    localparam t_scan SCAN_RESET = '{
        at_start:  1'b1,
        seg_len:   '0,
        tot_len:   '0,
        head:      '0,
        first_err: ST_OK
    };

    // lowercase letter or digit
    function automatic logic lower_alnum(input logic [7:0] c);
        lower_alnum = (c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_0 && c <= CH_9);
    endfunction

    // any character allowed after the segment start
    function automatic logic seg_char(input logic [7:0] c);
        seg_char = lower_alnum(c) || c == CH_UNDER || c == CH_DASH;
    endfunction

    // segment matches a reserved device name
    function automatic logic seg_reserved(input logic [8*HEAD_BYTES-1:0] head,
                                          input logic [SEG_W-1:0]        seg_len);
        logic three;
        logic four;
        three = (seg_len == SEG_W'(3)) &&
                (head[23:0] == RES_CON || head[23:0] == RES_PRN ||
                 head[23:0] == RES_AUX || head[23:0] == RES_NUL);
        four  = (seg_len == SEG_W'(4)) &&
                (head[23:0] == RES_COM || head[23:0] == RES_LPT) &&
                head[31:24] >= CH_1 && head[31:24] <= CH_9;
        seg_reserved = three || four;
    endfunction

endpackage

@@ rtl/core/isv_ifs.sv @@
// identifier segment validator: input and result channel interfaces
// no dependencies; valid/ready handshake with the payload fields alongside
`timescale 1ns / 1ps

interface isv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       dotted;
    logic       last_item;
    logic       empty_marker;

    modport source (output valid, char_byte, dotted, last_item, empty_marker, input ready);
    modport sink   (input valid, char_byte, dotted, last_item, empty_marker, output ready);
endinterface

interface isv_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;

    modport source (output valid, status, input ready);
    modport sink   (input valid, status, output ready);
endinterface

@@ rtl/core/isv_step.sv @@
// identifier segment validator: per-byte rule checks and end-of-string status
// depends on isv_pkg; purely combinational, one request per evaluation
`timescale 1ns / 1ps

module isv_step import isv_pkg::*; (
    input  t_scan   i_scan,
    input  t_item   i_item,
    output t_scan   o_scan,
    output t_status o_status
);

    t_scan      upd;
    logic [7:0] c;

    assign c = i_item.char_byte;

    // fold one byte into the running state
    always_comb begin
        upd = i_scan;
        if (!i_item.empty_marker) begin
            if (i_scan.tot_len <= TOT_W'(MAX_LENGTH)) begin
                upd.tot_len = i_scan.tot_len + TOT_W'(1);
            end
            if (i_scan.first_err == ST_OK) begin
                if (c < CH_SPACE || c == CH_DEL) begin
                    upd.first_err = ST_CONTROL;
                end else if (c == CH_DOT) begin
                    if (!i_item.dotted || i_scan.at_start) begin
                        upd.first_err = ST_BAD_DOT;
                    end else if (seg_reserved(i_scan.head, i_scan.seg_len)) begin
                        upd.first_err = ST_RESERVED;
                    end else begin
                        upd.at_start = 1'b1;
                        upd.seg_len  = '0;
                        upd.head     = '0;
                    end
                end else if (i_scan.at_start && !lower_alnum(c)) begin
                    upd.first_err = ST_BAD_START;
                end else if (!seg_char(c)) begin
                    upd.first_err = ST_BAD_CHAR;
                end else begin
                    upd.at_start = 1'b0;
                    // keep the leading bytes for the reserved name check
                    if (i_scan.seg_len < SEG_W'(HEAD_BYTES)) begin
                        upd.head[{i_scan.seg_len[1:0], 3'b000} +: 8] =
                            i_scan.head[{i_scan.seg_len[1:0], 3'b000} +: 8] | c;
                    end
                    if (i_scan.seg_len <= SEG_W'(MAX_SEGMENT)) begin
                        upd.seg_len = i_scan.seg_len + SEG_W'(1);
                    end
                    if (upd.seg_len > SEG_W'(MAX_SEGMENT)) begin
                        upd.first_err = ST_SEG_LONG;
                    end
                end
            end
        end
    end

    // end-of-string status, too long overrides a latched error
    always_comb begin
        if (upd.tot_len == '0) begin
            o_status = ST_EMPTY;
        end else if (upd.tot_len > TOT_W'(MAX_LENGTH)) begin
            o_status = ST_TOO_LONG;
        end else if (upd.first_err != ST_OK) begin
            o_status = upd.first_err;
        end else if (upd.at_start) begin
            o_status = ST_TRAIL_DOT;
        end else if (seg_reserved(upd.head, upd.seg_len)) begin
            o_status = ST_RESERVED;
        end else begin
            o_status = ST_OK;
        end
    end

    // the last request clears the state for the next string
    assign o_scan = i_item.last_item ? SCAN_RESET : upd;

endmodule

@@ rtl/core/identifier_segment_validator_top.sv @@
// identifier segment validator: top level with input register, state and result register
// depends on isv_pkg, isv_in_if / isv_out_if and isv_step
//
//   channel   dir   fields                                        request
//   i_in      in    char_byte, dotted, last_item, empty_marker    one byte of the identifier
//   o_out     out   status                                        one status per string
//
// one request is taken every cycle unless a last request waits on a stalled result; the result
// passes through the input register, then the result register fed by the byte-check logic
// a stalled result holds only requests marked last: plain bytes keep flowing
// reset is synchronous, active low, and clears the scan state and both valid flags
`timescale 1ns / 1ps

module identifier_segment_validator_top import isv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    isv_in_if.sink        i_in,
    isv_out_if.source     o_out
);

    logic    r_in_valid;
    t_item   r_in;
    t_scan   r_scan;
    logic    r_out_valid;
    t_status r_out_status;

    t_scan   n_scan;
    t_status step_status;
    logic    advance;

    // the held request moves on unless it carries a result that cannot be stored
    assign advance    = r_in_valid &&
                        (!r_in.last_item || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    isv_step u_step (
        .i_scan   (r_scan),
        .i_item   (r_in),
        .o_scan   (n_scan),
        .o_status (step_status)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.char_byte    <= i_in.char_byte;
            r_in.dotted       <= i_in.dotted;
            r_in.last_item    <= i_in.last_item;
            r_in.empty_marker <= i_in.empty_marker;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RESET;
        end else if (advance) begin
            r_scan <= n_scan;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last_item) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last_item) begin
            r_out_status <= step_status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;

endmodule
